[rtl/first_fit_extent_allocator_macros.svh]
// Assertion macros for the first-fit extent allocator checker.
// Included by the checker file only; no other dependencies.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off while in reset
`define FFEA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ffea assertion failed");

// Next-cycle implication, off while in reset
`define FFEA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ffea assertion failed");

`endif

[rtl/ffea_pkg.sv]
// Shared types and constants of the first-fit extent allocator.
// No dependencies; used by the interfaces, the controller and the checker.
package ffea_pkg;

    // Fixed field widths of the channel words
    localparam int unsigned ADDRESS_W = 16;
    localparam int unsigned LENGTH_W  = 17;
    localparam int unsigned CFG_IDX_W = 2;

    // Operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_BAD_LEN = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 2'd1;

    // Reset values of the configuration registers
    localparam logic [LENGTH_W-1:0] MAX_LENGTH_RST = 17'd4096;
    localparam logic [LENGTH_W-1:0] POOL_BYTES_RST = 17'd65536;

    typedef struct packed {
        logic [1:0]          operation;
        logic [ADDRESS_W-1:0] address;
        logic [LENGTH_W-1:0]  length;
    } req_t;

    typedef struct packed {
        logic [ADDRESS_W-1:0] block_address;
        logic [1:0]           status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_MERGE,
        ST_SHL,
        ST_SHR,
        ST_DONE
    } state_t;

endpackage

[rtl/ffea_if.sv]
// Valid/ready channel interfaces for request and response words.
// Depends on ffea_pkg for the payload types.
interface ffea_req_if;
    logic               valid;
    logic               ready;
    ffea_pkg::req_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffea_rsp_if;
    logic               valid;
    logic               ready;
    ffea_pkg::rsp_t     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ffea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffea_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ffea_ctrl.sv]
// Sequencer of the extent allocator: scans, merges and shifts the extent table.
// Depends on ffea_pkg and the channel interfaces; drives the table RAM ports.
module ffea_ctrl #(
    parameter int unsigned MAX_EXTENTS = 64,
    parameter int unsigned ADDR_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ffea_req_if.sink                               in_ch,
    ffea_rsp_if.source                             out_ch,
    input  logic                                   cfg_we,
    input  logic [ffea_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ffea_pkg::LENGTH_W-1:0]          cfg_wdata,
    output logic                                   ram_we,
    output logic [$clog2(MAX_EXTENTS)-1:0]         ram_waddr,
    output logic [2*ADDR_BITS:0]                   ram_wdata,
    output logic [$clog2(MAX_EXTENTS)-1:0]         ram_raddr,
    input  logic [2*ADDR_BITS:0]                   ram_rdata
);

    localparam int unsigned AW = ADDR_BITS;
    localparam int unsigned SW = ADDR_BITS + 1;
    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam int unsigned WW = ADDR_BITS + 18;
    localparam int unsigned LW = ffea_pkg::LENGTH_W;
    localparam int unsigned OW = ffea_pkg::ADDRESS_W;

    // Saturating size add
    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] x, input logic [SW-1:0] y);
        logic [SW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    ffea_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  ptr_reg, ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     op_reg;
    logic [AW-1:0]  a_reg;
    logic [LW-1:0]  n_reg;
    logic [AW-1:0]  st_reg, st_next;
    logic [SW-1:0]  acc_reg, acc_next;
    logic [OW-1:0]  res_addr_reg, res_addr_next;
    logic [1:0]     res_st_reg, res_st_next;
    logic [LW-1:0]  maxlen_reg;
    logic [LW-1:0]  pool_reg;
    logic           out_valid_reg;
    ffea_pkg::rsp_t out_data_reg;

    logic [WW-1:0]  addr_in_w;
    logic [AW-1:0]  q_start;
    logic [SW-1:0]  q_size;
    logic [SW-1:0]  n_s;
    logic [WW-1:0]  n_w, a_w, qs_w, qz_w, pend_w, space_w, end_w, pool_w, maxlen_w;
    logic [WW-1:0]  start_plus_w;
    logic [WW-1:0]  carve_w;
    logic [SW-1:0]  pool_s;
    logic           in_range, last, full, bad_len, pend_bad;
    logic           fit_exact, fit_big, f_break, f_front, f_back, m_next;
    logic           accept, out_free;

    // Table entry fields and widened operands
    assign q_start      = ram_rdata[2*AW:SW];
    assign q_size       = ram_rdata[SW-1:0];
    assign addr_in_w    = {{(WW-OW){1'b0}}, in_ch.data.address};
    assign n_w          = {{(WW-LW){1'b0}}, n_reg};
    assign n_s          = n_w[SW-1:0];
    assign a_w          = {{(WW-AW){1'b0}}, a_reg};
    assign qs_w         = {{(WW-AW){1'b0}}, q_start};
    assign qz_w         = {{(WW-SW){1'b0}}, q_size};
    assign pend_w       = a_w + n_w;
    assign end_w        = qs_w + qz_w;
    assign space_w      = {{(WW-1){1'b0}}, 1'b1} << AW;
    assign pool_w       = {{(WW-LW){1'b0}}, pool_reg};
    assign maxlen_w     = {{(WW-LW){1'b0}}, maxlen_reg};
    assign pool_s       = (pool_w > space_w) ? space_w[SW-1:0] : pool_w[SW-1:0];
    assign start_plus_w = qs_w + (qz_w - n_w);
    assign carve_w      = {{(WW-AW){1'b0}}, start_plus_w[AW-1:0]};

    // Decision flags
    assign in_range  = idx_reg < cnt_reg;
    assign last      = (idx_reg + 1'b1) == cnt_reg;
    assign full      = cnt_reg == CW'(MAX_EXTENTS);
    assign bad_len   = (n_reg == '0) || (n_w > maxlen_w);
    assign pend_bad  = pend_w > space_w;
    assign fit_exact = qz_w == n_w;
    assign fit_big   = qz_w > n_w;
    assign f_break   = qs_w > pend_w;
    assign f_front   = pend_w == qs_w;
    assign f_back    = end_w == a_w;
    assign m_next    = qs_w == pend_w;

    assign accept   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready  = state_reg == ffea_pkg::ST_IDLE;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Next state and datapath updates
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        st_next       = st_reg;
        acc_next      = acc_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        case (state_reg)
            ffea_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ffea_pkg::ST_DECODE;
                end
            end
            ffea_pkg::ST_DECODE:
            begin
                res_addr_next = '0;
                idx_next      = '0;
                if (op_reg == ffea_pkg::OP_INIT)
                begin
                    cnt_next    = (pool_s != '0) ? CW'(1) : '0;
                    res_st_next = ffea_pkg::STAT_OK;
                    state_next  = ffea_pkg::ST_DONE;
                end
                else if ((op_reg != ffea_pkg::OP_ALLOC && op_reg != ffea_pkg::OP_FREE)
                         || bad_len || (op_reg == ffea_pkg::OP_FREE && pend_bad))
                begin
                    res_st_next = ffea_pkg::STAT_BAD_LEN;
                    state_next  = ffea_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ffea_pkg::ST_SCAN;
                end
            end
            ffea_pkg::ST_SCAN:
            begin
                res_st_next = ffea_pkg::STAT_OK;
                if (op_reg == ffea_pkg::OP_ALLOC)
                begin
                    if (!in_range)
                    begin
                        res_st_next = ffea_pkg::STAT_OOM;
                        state_next  = ffea_pkg::ST_DONE;
                    end
                    else if (fit_exact)
                    begin
                        res_addr_next = qs_w[OW-1:0];
                        ptr_next      = idx_reg + 1'b1;
                        state_next    = ffea_pkg::ST_SHL;
                    end
                    else if (fit_big)
                    begin
                        res_addr_next = carve_w[OW-1:0];
                        state_next    = ffea_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!in_range || f_break)
                    begin
                        if (full)
                        begin
                            res_st_next = ffea_pkg::STAT_FULL;
                            state_next  = ffea_pkg::ST_DONE;
                        end
                        else
                        begin
                            ptr_next   = cnt_reg;
                            state_next = ffea_pkg::ST_SHR;
                        end
                    end
                    else if (f_front)
                    begin
                        state_next = ffea_pkg::ST_DONE;
                    end
                    else if (f_back)
                    begin
                        st_next  = q_start;
                        acc_next = sat_add(q_size, n_s);
                        if (last)
                        begin
                            state_next = ffea_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = ffea_pkg::ST_MERGE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ffea_pkg::ST_MERGE:
            begin
                if (m_next)
                begin
                    ptr_next   = idx_reg + CW'(2);
                    state_next = ffea_pkg::ST_SHL;
                end
                else
                begin
                    state_next = ffea_pkg::ST_DONE;
                end
            end
            ffea_pkg::ST_SHL:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ffea_pkg::ST_DONE;
                end
            end
            ffea_pkg::ST_SHR:
            begin
                if (ptr_reg == idx_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ffea_pkg::ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ffea_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ffea_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffea_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM write and read port drive
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IW-1:0];
        ram_wdata = {q_start, q_size};
        case (state_reg)
            ffea_pkg::ST_DECODE:
            begin
                ram_we    = (op_reg == ffea_pkg::OP_INIT) && (pool_s != '0);
                ram_waddr = '0;
                ram_wdata = {{AW{1'b0}}, pool_s};
            end
            ffea_pkg::ST_SCAN:
            begin
                if (in_range && op_reg == ffea_pkg::OP_ALLOC && !fit_exact && fit_big)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {q_start, q_size - n_s};
                end
                else if (in_range && op_reg == ffea_pkg::OP_FREE && !f_break && f_front)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {a_reg, sat_add(q_size, n_s)};
                end
                else if (in_range && op_reg == ffea_pkg::OP_FREE && !f_break && f_back && last)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {q_start, sat_add(q_size, n_s)};
                end
                else
                begin
                    ram_we = 1'b0;
                end
            end
            ffea_pkg::ST_MERGE:
            begin
                ram_we    = 1'b1;
                ram_wdata = m_next ? {st_reg, sat_add(acc_reg, q_size)} : {st_reg, acc_reg};
            end
            ffea_pkg::ST_SHL:
            begin
                ram_we    = ptr_reg < cnt_reg;
                ram_waddr = ptr_reg[IW-1:0] - 1'b1;
            end
            ffea_pkg::ST_SHR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[IW-1:0];
                if (ptr_reg == idx_reg)
                begin
                    ram_wdata = {a_reg, n_s};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Read the entry that the next cycle works on
    always_comb
    begin
        case (state_next)
            ffea_pkg::ST_SCAN:  ram_raddr = idx_next[IW-1:0];
            ffea_pkg::ST_MERGE: ram_raddr = idx_reg[IW-1:0] + 1'b1;
            ffea_pkg::ST_SHL:   ram_raddr = ptr_next[IW-1:0];
            ffea_pkg::ST_SHR:   ram_raddr = ptr_next[IW-1:0] - 1'b1;
            default:            ram_raddr = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffea_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            maxlen_reg    <= ffea_pkg::MAX_LENGTH_RST;
            pool_reg      <= ffea_pkg::POOL_BYTES_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ffea_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == ffea_pkg::CFG_MAX_LENGTH)
            begin
                maxlen_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == ffea_pkg::CFG_POOL_BYTES)
            begin
                pool_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        st_reg       <= st_next;
        acc_reg      <= acc_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
        if (accept)
        begin
            op_reg <= in_ch.data.operation;
            a_reg  <= addr_in_w[AW-1:0];
            n_reg  <= in_ch.data.length;
        end
        if (state_reg == ffea_pkg::ST_DONE && out_free)
        begin
            out_data_reg.block_address <= res_addr_reg;
            out_data_reg.status        <= res_st_reg;
        end
    end

endmodule

[rtl/first_fit_extent_allocator.sv]
// First-fit free-extent allocator with coalescing; top level.
// Uses ffea_pkg, the channel interfaces, ffea_ctrl and ffea_ram.
//
// Usage: in_ch takes one word per operation (allocate, free, init) with
// valid/ready; out_ch returns exactly one word (block_address, status) per
// accepted word. cfg_we/cfg_index/cfg_wdata write max_length (index 0) and
// pool_bytes (index 1); the user writes them only while the block is idle,
// which the block does not enforce. The extent table lives in one RAM of
// MAX_EXTENTS entries read one entry per cycle. An item is decoded, scans
// the extents in order, may merge with the following extent, and moves
// entries on removal or insertion before it closes the shift; the single
// read port of the table RAM is why entries are handled one at a time.
// One item is in work at a time; in_ch.ready is high only while idle.
// Reset empties the table (count zero) and loads max_length 4096 and
// pool_bytes 65536; an init word is needed before allocation succeeds.
// When out_ch stalls, the finished word is held in the output register
// and the next item waits in the done state until the output frees.
module first_fit_extent_allocator #(
    parameter int unsigned MAX_EXTENTS = 64,
    parameter int unsigned ADDR_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ffea_req_if.sink                        in_ch,
    ffea_rsp_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [ffea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffea_pkg::LENGTH_W-1:0]   cfg_wdata
);

    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned EW = 2 * ADDR_BITS + 1;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    ffea_ctrl #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Extent table: start in the upper bits, size in the lower bits
    ffea_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EXTENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[rtl/ffea_checker.sv]
// Port-level checker for the first-fit extent allocator, bound to the top.
// Depends on ffea_pkg and first_fit_extent_allocator_macros.svh.
`include "first_fit_extent_allocator_macros.svh"

module ffea_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_addr,
    input logic [1:0]  out_status
);

    // Hold a stalled word
    `FFEA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `FFEA_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_addr) && $stable(out_status))
    // Failed words carry a zero address
    `FFEA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_status != ffea_pkg::STAT_OK, out_addr == 16'd0)
    // One item in work at a time
    `FFEA_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_addr   (out_ch.data.block_address),
    .out_status (out_ch.data.status)
);
